@@ rtl/stg_pkg.sv @@
// Shared types, widths and helper functions for the septic trajectory generator.
`default_nettype none

package stg_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int JOINT_W     = 4;
    localparam int INDEX_W     = 6;
    localparam int CFG_W       = 7;
    localparam int VAL_W       = 32;
    localparam int COEF_W      = 64;
    localparam int ACC_W       = 128;
    localparam int DVS_W       = 48;
    localparam int REM_W       = DVS_W + VAL_W;
    localparam int NUM_COEF    = 8;
    localparam int NUM_DERIV   = 4;
    localparam int PIPE_DEPTH  = NUM_COEF + 2 + VAL_W;

    localparam logic CFG_FINAL_TIME  = 1'b0;
    localparam logic CFG_NUM_SAMPLES = 1'b1;

    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [DVS_W-1:0]  dvs_t;
    typedef logic [REM_W-1:0]  rem_t;
    typedef logic [CFG_W-1:0]  cfg_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint_index;
        val_t               start_position;
        val_t               start_velocity;
        val_t               start_acceleration;
        val_t               start_jerk;
        val_t               end_position;
        val_t               end_velocity;
        val_t               end_acceleration;
        val_t               end_jerk;
    } item_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint_out;
        logic [INDEX_W-1:0] sample_index;
        val_t               position;
        val_t               velocity;
        val_t               acceleration;
        val_t               jerk;
        logic               last;
    } sample_t;

    // Falling factorial i!/(i-n)! for the derivative of order n.
    function automatic logic [7:0] falling(input int i, input int n);
        int f;
        f = 1;
        for (int j = 0; j < n; j++) begin
            f = f * (i - j);
        end
        return 8'(f);
    endfunction

    // Applies the sign to a floor quotient and saturates to 32 bits.
    function automatic val_t sat_quotient(input val_t q, input logic big, input logic neg);
        val_t r;
        if (!neg) begin
            r = (big || q[VAL_W-1]) ? {1'b0, {(VAL_W-1){1'b1}}} : q;
        end
        else if (big || (q[VAL_W-1] && (q[VAL_W-2:0] != '0))) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else begin
            r = ~q + val_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/septic_trajectory_generator.sv @@
// Top level of the septic polynomial trajectory generator.
// One item is taken at a time: a coefficient solve, then N samples issued one per cycle
// while the output is not stalled, into a 42-stage evaluation pipeline and an output
// register. The next item is accepted only once the previous item's samples have left
// the evaluation pipeline.
// Reset clears the sequencer, all valid bits and sets final_time to 1 and num_samples to 2.
`default_nettype none

module septic_trajectory_generator (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire stg_pkg::item_t  item,
    output logic                 sample_valid,
    input  wire logic            sample_stall,
    output stg_pkg::sample_t     sample,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_index,
    input  wire stg_pkg::cfg_t   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCALE, ST_COMB, ST_LIN, ST_POW, ST_GEN, ST_RUN, ST_DRAIN
    } state_t;

    state_t state_reg;
    logic [2:0] cnt_reg;
    logic [stg_pkg::INDEX_W-1:0] kcnt_reg;
    stg_pkg::cfg_t ft_reg;
    stg_pkg::cfg_t ns_reg;

    logic [stg_pkg::CFG_W-1:0] t_reg;
    logic [stg_pkg::INDEX_W-1:0] m_reg;
    logic [stg_pkg::JOINT_W-1:0] joint_reg;
    stg_pkg::coef_t p0_reg, v0_reg, a0_reg, j0_reg, p1_reg, v1_reg, a1_reg, j1_reg;
    stg_pkg::coef_t h_reg [stg_pkg::NUM_COEF];
    stg_pkg::coef_t e_reg [stg_pkg::NUM_DERIV];
    stg_pkg::acc_t  q_reg [stg_pkg::NUM_COEF];
    stg_pkg::acc_t  g_reg [stg_pkg::NUM_DERIV][stg_pkg::NUM_COEF];
    stg_pkg::dvs_t  d_reg [stg_pkg::NUM_DERIV];

    logic [0:stg_pkg::PIPE_DEPTH-1] valid_reg;
    logic [stg_pkg::INDEX_W-1:0] k_pipe_reg [stg_pkg::PIPE_DEPTH];
    logic [stg_pkg::JOINT_W-1:0] joint_pipe_reg [stg_pkg::PIPE_DEPTH];
    logic last_pipe_reg [stg_pkg::PIPE_DEPTH];

    stg_pkg::acc_t hacc_reg [stg_pkg::NUM_COEF][stg_pkg::NUM_DERIV];
    stg_pkg::acc_t num_reg [stg_pkg::NUM_DERIV];
    logic          sgn8_reg [stg_pkg::NUM_DERIV];
    stg_pkg::rem_t rem_reg [stg_pkg::VAL_W+1][stg_pkg::NUM_DERIV];
    stg_pkg::val_t quo_reg [stg_pkg::VAL_W+1][stg_pkg::NUM_DERIV];
    logic          big_reg [stg_pkg::VAL_W+1][stg_pkg::NUM_DERIV];
    logic          sgn_reg [stg_pkg::VAL_W+1][stg_pkg::NUM_DERIV];

    logic out_valid_reg;
    stg_pkg::sample_t sample_reg;

    logic item_accept;
    logic en;
    logic issue;
    logic [stg_pkg::CFG_W-1:0] t_clamp;
    logic [stg_pkg::CFG_W-1:0] n_clamp;
    stg_pkg::coef_t g0, g1, g2, g3;
    stg_pkg::coef_t lin [stg_pkg::NUM_DERIV];

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign en           = !out_valid_reg || !sample_stall;
    assign issue        = (state_reg == ST_RUN);
    assign sample_valid = out_valid_reg;
    assign sample       = sample_reg;

    always_comb
    begin
        if (ft_reg == '0)
        begin
            t_clamp = stg_pkg::CFG_W'(1);
        end
        else if (ft_reg > stg_pkg::CFG_W'(64))
        begin
            t_clamp = stg_pkg::CFG_W'(64);
        end
        else
        begin
            t_clamp = ft_reg;
        end
        if (ns_reg < stg_pkg::CFG_W'(2))
        begin
            n_clamp = stg_pkg::CFG_W'(2);
        end
        else if (ns_reg > stg_pkg::CFG_W'(stg_pkg::MAX_SAMPLES))
        begin
            n_clamp = stg_pkg::CFG_W'(stg_pkg::MAX_SAMPLES);
        end
        else
        begin
            n_clamp = ns_reg;
        end
    end

    // Boundary combinations, all modulo 2^64.
    always_comb
    begin
        g0 = p0_reg * 64'd6;
        g1 = v0_reg * 64'd6;
        g2 = a0_reg * 64'd3;
        g3 = j0_reg;
        lin[0] = e_reg[0] * 64'd210 - e_reg[1] * 64'd90 + e_reg[2] * 64'd15 - e_reg[3];
        lin[1] = e_reg[1] * 64'd234 + e_reg[3] * 64'd3 - e_reg[0] * 64'd504
                 - e_reg[2] * 64'd42;
        lin[2] = e_reg[0] * 64'd420 - e_reg[1] * 64'd204 + e_reg[2] * 64'd39
                 - e_reg[3] * 64'd3;
        lin[3] = e_reg[1] * 64'd60 + e_reg[3] - e_reg[0] * 64'd120 - e_reg[2] * 64'd12;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            kcnt_reg  <= '0;
            ft_reg    <= stg_pkg::CFG_W'(1);
            ns_reg    <= stg_pkg::CFG_W'(2);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    stg_pkg::CFG_FINAL_TIME:  ft_reg <= cfg_data;
                    stg_pkg::CFG_NUM_SAMPLES: ns_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_accept)
                    begin
                        state_reg <= ST_SCALE;
                        cnt_reg   <= '0;
                    end
                end
                ST_SCALE:
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        state_reg <= ST_COMB;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                ST_COMB: state_reg <= ST_LIN;
                ST_LIN:
                begin
                    state_reg <= ST_POW;
                    cnt_reg   <= '0;
                end
                ST_POW:
                begin
                    if (cnt_reg == 3'd6)
                    begin
                        state_reg <= ST_GEN;
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                end
                ST_GEN:
                begin
                    state_reg <= ST_RUN;
                    kcnt_reg  <= '0;
                end
                ST_RUN:
                begin
                    if (en)
                    begin
                        if (kcnt_reg == m_reg)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        kcnt_reg <= kcnt_reg + stg_pkg::INDEX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (valid_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Coefficient solve datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    t_reg     <= t_clamp;
                    m_reg     <= stg_pkg::INDEX_W'(n_clamp - stg_pkg::CFG_W'(1));
                    joint_reg <= item.joint_index;
                    p0_reg    <= 64'(signed'(item.start_position));
                    v0_reg    <= 64'(signed'(item.start_velocity));
                    a0_reg    <= 64'(signed'(item.start_acceleration));
                    j0_reg    <= 64'(signed'(item.start_jerk));
                    p1_reg    <= 64'(signed'(item.end_position));
                    v1_reg    <= 64'(signed'(item.end_velocity));
                    a1_reg    <= 64'(signed'(item.end_acceleration));
                    j1_reg    <= 64'(signed'(item.end_jerk));
                    for (int n = 0; n < stg_pkg::NUM_DERIV; n++)
                    begin
                        d_reg[n] <= stg_pkg::dvs_t'(36);
                    end
                end
            end
            ST_SCALE:
            begin
                j0_reg <= j0_reg * stg_pkg::coef_t'(t_reg);
                j1_reg <= j1_reg * stg_pkg::coef_t'(t_reg);
                if (cnt_reg < 3'd2)
                begin
                    a0_reg <= a0_reg * stg_pkg::coef_t'(t_reg);
                    a1_reg <= a1_reg * stg_pkg::coef_t'(t_reg);
                end
                if (cnt_reg == 3'd0)
                begin
                    v0_reg <= v0_reg * stg_pkg::coef_t'(t_reg);
                    v1_reg <= v1_reg * stg_pkg::coef_t'(t_reg);
                end
            end
            ST_COMB:
            begin
                e_reg[0] <= p1_reg * 64'd6 - g0 - g1 - g2 - g3;
                e_reg[1] <= v1_reg * 64'd6 - g1 - g2 * 64'd2 - g3 * 64'd3;
                e_reg[2] <= a1_reg * 64'd6 - g2 * 64'd2 - g3 * 64'd6;
                e_reg[3] <= j1_reg * 64'd6 - g3 * 64'd6;
                h_reg[0] <= g0 * 64'd6;
                h_reg[1] <= g1 * 64'd6;
                h_reg[2] <= g2 * 64'd6;
                h_reg[3] <= g3 * 64'd6;
            end
            ST_LIN:
            begin
                for (int i = 0; i < stg_pkg::NUM_DERIV; i++)
                begin
                    h_reg[i + 4] <= lin[i];
                    q_reg[i]     <= stg_pkg::acc_t'(signed'(h_reg[i]));
                    q_reg[i + 4] <= stg_pkg::acc_t'(signed'(lin[i]));
                end
            end
            ST_POW:
            begin
                for (int i = 0; i < stg_pkg::NUM_COEF; i++)
                begin
                    if (int'(cnt_reg) < 7 - i)
                    begin
                        q_reg[i] <= q_reg[i] * stg_pkg::acc_t'(m_reg);
                    end
                end
                for (int n = 0; n < stg_pkg::NUM_DERIV; n++)
                begin
                    d_reg[n] <= d_reg[n] * ((int'(cnt_reg) < 7 - n) ?
                                stg_pkg::dvs_t'(m_reg) : stg_pkg::dvs_t'(t_reg));
                end
            end
            ST_GEN:
            begin
                for (int n = 0; n < stg_pkg::NUM_DERIV; n++)
                begin
                    for (int i = 0; i < stg_pkg::NUM_COEF; i++)
                    begin
                        g_reg[n][i] <= (i >= n) ?
                            q_reg[i] * stg_pkg::acc_t'(stg_pkg::falling(i, n)) : '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Valid bits of the evaluation pipeline and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {issue, valid_reg[0:stg_pkg::PIPE_DEPTH-2]};
            out_valid_reg <= valid_reg[stg_pkg::PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_pipe_reg[0]     <= kcnt_reg;
            joint_pipe_reg[0] <= joint_reg;
            last_pipe_reg[0]  <= (kcnt_reg == m_reg);
            for (int s = 1; s < stg_pkg::PIPE_DEPTH; s++)
            begin
                k_pipe_reg[s]     <= k_pipe_reg[s-1];
                joint_pipe_reg[s] <= joint_pipe_reg[s-1];
                last_pipe_reg[s]  <= last_pipe_reg[s-1];
            end
        end
    end

    // Horner evaluation: stage s folds in coefficient 7-s for each derivative lane n <= 7-s; other lanes pass through.
    for (genvar s = 0; s < stg_pkg::NUM_COEF; s++)
    begin : g_horner
        for (genvar n = 0; n < stg_pkg::NUM_DERIV; n++)
        begin : g_lane
            stg_pkg::acc_t src;
            stg_pkg::acc_t kk;
            if (s == 0)
            begin : g_first
                assign src = '0;
                assign kk  = stg_pkg::acc_t'(kcnt_reg);
            end
            else
            begin : g_next
                assign src = hacc_reg[s-1][n];
                assign kk  = stg_pkg::acc_t'(k_pipe_reg[s-1]);
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (7 - s >= n)
                    begin
                        hacc_reg[s][n] <= src * kk + g_reg[n][7-s];
                    end
                    else
                    begin
                        hacc_reg[s][n] <= src;
                    end
                end
            end
        end
    end

    // Floor division by 36 * M^(7-n) * T^n, one quotient bit per stage.
    for (genvar n = 0; n < stg_pkg::NUM_DERIV; n++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sgn8_reg[n] <= hacc_reg[stg_pkg::NUM_COEF-1][n][stg_pkg::ACC_W-1];
                num_reg[n]  <= hacc_reg[stg_pkg::NUM_COEF-1][n][stg_pkg::ACC_W-1] ?
                               ~hacc_reg[stg_pkg::NUM_COEF-1][n] + stg_pkg::acc_t'(d_reg[n]) :
                               hacc_reg[stg_pkg::NUM_COEF-1][n];
                sgn_reg[0][n] <= sgn8_reg[n];
                big_reg[0][n] <= (num_reg[n][stg_pkg::ACC_W-1:stg_pkg::REM_W] != '0) ||
                                 (num_reg[n][stg_pkg::REM_W-1:0] >=
                                  {d_reg[n], {stg_pkg::VAL_W{1'b0}}});
                rem_reg[0][n] <= num_reg[n][stg_pkg::REM_W-1:0];
                quo_reg[0][n] <= '0;
            end
        end
        for (genvar j = 1; j <= stg_pkg::VAL_W; j++)
        begin : g_bit
            stg_pkg::rem_t trial;
            assign trial = stg_pkg::rem_t'(d_reg[n]) << (stg_pkg::VAL_W - j);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sgn_reg[j][n] <= sgn_reg[j-1][n];
                    big_reg[j][n] <= big_reg[j-1][n];
                    if (rem_reg[j-1][n] >= trial)
                    begin
                        rem_reg[j][n] <= rem_reg[j-1][n] - trial;
                        quo_reg[j][n] <= quo_reg[j-1][n] |
                                         (stg_pkg::val_t'(1) << (stg_pkg::VAL_W - j));
                    end
                    else
                    begin
                        rem_reg[j][n] <= rem_reg[j-1][n];
                        quo_reg[j][n] <= quo_reg[j-1][n];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg.joint_out    <= joint_pipe_reg[stg_pkg::PIPE_DEPTH-1];
            sample_reg.sample_index <= k_pipe_reg[stg_pkg::PIPE_DEPTH-1];
            sample_reg.last         <= last_pipe_reg[stg_pkg::PIPE_DEPTH-1];
            sample_reg.position     <= stg_pkg::sat_quotient(quo_reg[stg_pkg::VAL_W][0],
                                       big_reg[stg_pkg::VAL_W][0], sgn_reg[stg_pkg::VAL_W][0]);
            sample_reg.velocity     <= stg_pkg::sat_quotient(quo_reg[stg_pkg::VAL_W][1],
                                       big_reg[stg_pkg::VAL_W][1], sgn_reg[stg_pkg::VAL_W][1]);
            sample_reg.acceleration <= stg_pkg::sat_quotient(quo_reg[stg_pkg::VAL_W][2],
                                       big_reg[stg_pkg::VAL_W][2], sgn_reg[stg_pkg::VAL_W][2]);
            sample_reg.jerk         <= stg_pkg::sat_quotient(quo_reg[stg_pkg::VAL_W][3],
                                       big_reg[stg_pkg::VAL_W][3], sgn_reg[stg_pkg::VAL_W][3]);
        end
    end

endmodule

`default_nettype wire
